// ===== hw/rtl/baro_temp_pressure_compensation_assert.svh =====
// Assertion macros shared by the compensation block RTL
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BTPC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BTPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/btpc_pkg.sv =====
// Shared types and constants for the barometric compensation pipeline
package btpc_pkg;

  localparam int DIV_NUM_W  = 76;
  localparam int DIV_DEN_W  = 50;
  localparam int DIV_Q_W    = 27;
  localparam int DIV_WIDE_W = DIV_DEN_W + DIV_Q_W;
  localparam int DIV_LAT    = DIV_Q_W + 2;

  localparam int B6_OFFSET   = 4000;
  localparam int B4_BIAS     = 32768;
  localparam int PRESS_SCALE = 50000;
  localparam int CURVE_SQ    = 3038;
  localparam int CURVE_LIN   = 7357;
  localparam int CURVE_OFS   = 3791;
  localparam int P_RAW_LIMIT = 262143;
  localparam int P_MAX       = 131071;

  typedef logic signed [DIV_NUM_W-1:0] div_num_t;
  typedef logic signed [DIV_DEN_W-1:0] div_den_t;
  typedef logic [DIV_NUM_W-1:0]        div_mag_t;
  typedef logic [DIV_DEN_W-1:0]        div_dmag_t;
  typedef logic [DIV_WIDE_W-1:0]       div_wide_t;
  typedef logic [DIV_Q_W-1:0]          div_q_t;

  typedef struct packed {
    div_q_t mag;
    logic   neg;
    logic   ovf;
    logic   dz;
  } div_res_t;

  typedef enum logic [2:0] {
    REG_OFFSET_PAIR  = 3'd0,
    REG_OFFSET_THIRD = 3'd1,
    REG_SENS         = 3'd2,
    REG_SQ_ONE       = 3'd3,
    REG_SQ_TWO       = 3'd4,
    REG_TEMP_LIN     = 3'd5,
    REG_TEMP_CURVE   = 3'd6,
    REG_OSS          = 3'd7
  } cfg_reg_t;

endpackage

// ===== hw/rtl/btpc_div.sv =====
// Pipelined signed divider, one quotient bit per stage, with overflow and zero flags
module btpc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ce,
  input  logic                in_valid,
  input  btpc_pkg::div_num_t  in_num,
  input  btpc_pkg::div_den_t  in_den,
  output logic                out_valid,
  output btpc_pkg::div_res_t  out_res
);

  `include "baro_temp_pressure_compensation_assert.svh"

  logic                 a_v_r;
  btpc_pkg::div_mag_t   a_n_r;
  btpc_pkg::div_dmag_t  a_d_r;
  logic                 a_neg_r;
  logic                 a_dz_r;
  btpc_pkg::div_mag_t   a_n_nxt;
  btpc_pkg::div_dmag_t  a_d_nxt;
  logic                 ovf_nxt;

  logic [btpc_pkg::DIV_Q_W:0] v_r;
  logic [btpc_pkg::DIV_Q_W:0] neg_r;
  logic [btpc_pkg::DIV_Q_W:0] ovf_r;
  logic [btpc_pkg::DIV_Q_W:0] dz_r;
  btpc_pkg::div_mag_t   rem_r [btpc_pkg::DIV_Q_W+1];
  btpc_pkg::div_dmag_t  d_r   [btpc_pkg::DIV_Q_W+1];
  btpc_pkg::div_q_t     q_r   [btpc_pkg::DIV_Q_W+1];

  logic                 take_w [btpc_pkg::DIV_Q_W];
  btpc_pkg::div_mag_t   sub_w  [btpc_pkg::DIV_Q_W];

  assign a_n_nxt = in_num[btpc_pkg::DIV_NUM_W-1] ? btpc_pkg::div_mag_t'(-in_num)
                                                 : btpc_pkg::div_mag_t'(in_num);
  assign a_d_nxt = in_den[btpc_pkg::DIV_DEN_W-1] ? btpc_pkg::div_dmag_t'(-in_den)
                                                 : btpc_pkg::div_dmag_t'(in_den);
  // quotient would not fit in DIV_Q_W bits
  assign ovf_nxt = btpc_pkg::div_wide_t'(a_n_r) >=
                   (btpc_pkg::div_wide_t'(a_d_r) << btpc_pkg::DIV_Q_W);

  always_comb begin
    btpc_pkg::div_wide_t dsh;
    for (int i = 0; i < btpc_pkg::DIV_Q_W; i++) begin
      dsh       = btpc_pkg::div_wide_t'(d_r[i]) << (btpc_pkg::DIV_Q_W - 1 - i);
      take_w[i] = btpc_pkg::div_wide_t'(rem_r[i]) >= dsh;
      sub_w[i]  = btpc_pkg::div_mag_t'(btpc_pkg::div_wide_t'(rem_r[i]) - dsh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      v_r   <= '0;
    end else if (ce) begin
      a_v_r <= in_valid;
      v_r   <= {v_r[btpc_pkg::DIV_Q_W-1:0], a_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_n_r    <= a_n_nxt;
      a_d_r    <= a_d_nxt;
      a_neg_r  <= in_num[btpc_pkg::DIV_NUM_W-1] ^ in_den[btpc_pkg::DIV_DEN_W-1];
      a_dz_r   <= (in_den == '0);
      rem_r[0] <= a_n_r;
      d_r[0]   <= a_d_r;
      q_r[0]   <= '0;
      neg_r[0] <= a_neg_r;
      ovf_r[0] <= ovf_nxt;
      dz_r[0]  <= a_dz_r;
      for (int i = 0; i < btpc_pkg::DIV_Q_W; i++) begin
        rem_r[i+1] <= take_w[i] ? sub_w[i] : rem_r[i];
        d_r[i+1]   <= d_r[i];
        q_r[i+1]   <= q_r[i] | (btpc_pkg::div_q_t'(take_w[i]) << (btpc_pkg::DIV_Q_W - 1 - i));
        neg_r[i+1] <= neg_r[i];
        ovf_r[i+1] <= ovf_r[i];
        dz_r[i+1]  <= dz_r[i];
      end
    end
  end

  assign out_valid = v_r[btpc_pkg::DIV_Q_W];
  assign out_res   = '{mag: q_r[btpc_pkg::DIV_Q_W], neg: neg_r[btpc_pkg::DIV_Q_W],
                       ovf: ovf_r[btpc_pkg::DIV_Q_W], dz: dz_r[btpc_pkg::DIV_Q_W]};

  `BTPC_ASSERT_IMPLY(a_div_zero_ovf, out_valid && dz_r[btpc_pkg::DIV_Q_W], ovf_r[btpc_pkg::DIV_Q_W], "zero divisor without overflow flag")
  `BTPC_ASSERT_IMPLY(a_div_rem_bound, out_valid && !ovf_r[btpc_pkg::DIV_Q_W], rem_r[btpc_pkg::DIV_Q_W] < d_r[btpc_pkg::DIV_Q_W], "remainder not below divisor")

endmodule

// ===== hw/rtl/baro_temp_pressure_compensation.sv =====
// Pipeline: 69 register stages, two 29-stage dividers plus 11 single stages, the first
// loaded at the input accept edge and the last driving out_tvalid.
// Throughput: one item per cycle; a stall on out_tready holds every stage in place.
// Rate is set by the two bit-per-stage divider pipelines, which take a new item each cycle while ce is high.
// Reset (rst_n low, synchronous) clears all valid bits and loads the factory calibration
// defaults into the configuration registers.
module baro_temp_pressure_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] raw_temperature, [39:16] raw_pressure
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] temperature_tenths, [32:16] pressure_pa,
                                  // [33] math_error, [39:34] zero
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  `include "baro_temp_pressure_compensation_assert.svh"

  typedef struct packed {
    logic signed [18:0] x1;
    logic [23:0]        up;
  } tside_t;

  typedef struct packed {
    logic [15:0] t;
    logic        err;
  } pside_t;

  typedef enum logic [1:0] {PM_CALC, PM_ZERO, PM_MAX} pmode_t;

  // configuration
  logic [31:0] ocp_r, tlin_r, tcurve_r;
  logic [15:0] oc3_r, sens_r, sq1_r, sq2_r;
  logic [1:0]  oss_r;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = $signed(ocp_r[31:16]);
  assign ac2 = $signed(ocp_r[15:0]);
  assign ac3 = $signed(oc3_r);
  assign ac4 = sens_r;
  assign b1  = $signed(sq1_r);
  assign b2  = $signed(sq2_r);
  assign ac5 = tlin_r[31:16];
  assign ac6 = tlin_r[15:0];
  assign mc  = $signed(tcurve_r[31:16]);
  assign md  = $signed(tcurve_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocp_r    <= 32'd26804152;
      oc3_r    <= 16'd51153;
      sens_r   <= 16'd32741;
      sq1_r    <= 16'd6190;
      sq2_r    <= 16'd4;
      tlin_r   <= 32'd2146785905;
      tcurve_r <= 32'd3724086068;
      oss_r    <= 2'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        btpc_pkg::REG_OFFSET_PAIR:  ocp_r    <= cfg_wdata;
        btpc_pkg::REG_OFFSET_THIRD: oc3_r    <= cfg_wdata[15:0];
        btpc_pkg::REG_SENS:         sens_r   <= cfg_wdata[15:0];
        btpc_pkg::REG_SQ_ONE:       sq1_r    <= cfg_wdata[15:0];
        btpc_pkg::REG_SQ_TWO:       sq2_r    <= cfg_wdata[15:0];
        btpc_pkg::REG_TEMP_LIN:     tlin_r   <= cfg_wdata;
        btpc_pkg::REG_TEMP_CURVE:   tcurve_r <= cfg_wdata;
        btpc_pkg::REG_OSS:          oss_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic ce;
  logic out_tvalid_r;
  assign ce        = !out_tvalid_r || out_tready;
  assign in_tready = ce;

  // stage A: input capture
  logic        a_v_r;
  logic [15:0] a_ut_r;
  logic [23:0] a_up_r;

  // stage B: (ut - ac6) * ac5
  logic               b_v_r;
  logic signed [16:0] b_d;
  logic signed [33:0] b_prod_nxt, b_prod_r;
  logic [23:0]        b_up_r;

  assign b_d        = $signed({1'b0, a_ut_r}) - $signed({1'b0, ac6});
  assign b_prod_nxt = b_d * $signed({1'b0, ac5});

  // temperature divider feed
  logic signed [18:0]  c_x1;
  logic signed [19:0]  c_den;
  logic signed [26:0]  c_num;
  btpc_pkg::div_num_t  tdiv_num;
  btpc_pkg::div_den_t  tdiv_den;
  logic                tdiv_v;
  btpc_pkg::div_res_t  tdiv_res;
  tside_t              ts_r [btpc_pkg::DIV_LAT];

  assign c_x1     = b_prod_r[33:15];
  assign c_den    = c_x1 + md;
  assign c_num    = {mc, 11'b0};
  assign tdiv_num = btpc_pkg::div_num_t'(c_num);
  assign tdiv_den = btpc_pkg::div_den_t'(c_den);

  btpc_div u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (b_v_r),
    .in_num    (tdiv_num),
    .in_den    (tdiv_den),
    .out_valid (tdiv_v),
    .out_res   (tdiv_res)
  );

  // stage D: b5
  logic               d_v_r, d_err_r;
  logic signed [27:0] d_x2;
  logic signed [28:0] d_b5_nxt, d_b5_r;
  logic [23:0]        d_up_r;
  tside_t             ts_out;

  assign ts_out   = ts_r[btpc_pkg::DIV_LAT-1];
  assign d_x2     = tdiv_res.dz  ? 28'sd0 :
                    tdiv_res.neg ? -$signed({1'b0, tdiv_res.mag}) : $signed({1'b0, tdiv_res.mag});
  assign d_b5_nxt = ts_out.x1 + d_x2;

  // stage E: temperature out, b6 products
  logic               e_v_r, e_err_r;
  logic signed [29:0] e_b5p8, e_b6;
  logic signed [25:0] e_tq;
  logic [15:0]        e_t_nxt, e_t_r;
  logic signed [59:0] e_sqp_nxt, e_sqp_r;
  logic signed [45:0] e_a2_nxt, e_a2_r, e_a3_nxt, e_a3_r;
  logic [23:0]        e_up_r;

  assign e_b5p8    = d_b5_r + 30'sd8;
  assign e_tq      = e_b5p8[29:4];
  assign e_b6      = d_b5_r - 30'(btpc_pkg::B6_OFFSET);
  assign e_sqp_nxt = e_b6 * e_b6;
  assign e_a2_nxt  = ac2 * e_b6;
  assign e_a3_nxt  = ac3 * e_b6;

  always_comb begin
    if (e_tq > 26'sd32767) begin
      e_t_nxt = 16'h7FFF;
    end else if (e_tq < -26'sd32768) begin
      e_t_nxt = 16'h8000;
    end else begin
      e_t_nxt = e_tq[15:0];
    end
  end

  // stage F: squared-term products
  logic               f_v_r, f_err_r;
  logic signed [47:0] f_sq;
  logic signed [63:0] f_b2sq_nxt, f_b2sq_r, f_b1sq_nxt, f_b1sq_r;
  logic signed [45:0] f_a2_r, f_a3_r;
  logic [15:0]        f_t_r;
  logic [23:0]        f_up_r;

  assign f_sq       = e_sqp_r[59:12];
  assign f_b2sq_nxt = b2 * f_sq;
  assign f_b1sq_nxt = b1 * f_sq;

  // stage G: offset and divisor sums
  logic               g_v_r, g_err_r;
  logic signed [52:0] g_b2x;
  logic signed [34:0] g_a2x;
  logic signed [53:0] g_x3;
  logic signed [17:0] g_ac1x4;
  logic signed [54:0] g_s_nxt, g_s_r;
  logic signed [48:0] g_q_nxt, g_q_r;
  logic signed [32:0] g_a3x;
  logic signed [47:0] g_b1x;
  logic [15:0]        g_t_r;
  logic [23:0]        g_up_r;

  assign g_b2x   = f_b2sq_r[63:11];
  assign g_a2x   = f_a2_r[45:11];
  assign g_x3    = g_b2x + g_a2x;
  assign g_ac1x4 = {ac1, 2'b00};
  assign g_s_nxt = g_ac1x4 + g_x3;
  assign g_a3x   = f_a3_r[45:13];
  assign g_b1x   = f_b1sq_r[63:16];
  assign g_q_nxt = g_a3x + g_b1x + 49'sd2;

  // stage H: b3 and b4 operand
  logic               h_v_r, h_err_r;
  logic signed [58:0] h_ext, h_n, h_adj;
  logic signed [56:0] h_b3_r;
  logic signed [46:0] h_qs;
  logic signed [47:0] h_x3_nxt, h_x3_r;
  logic [15:0]        h_t_r;
  logic [23:0]        h_up_r;

  assign h_ext    = g_s_r;
  assign h_n      = (h_ext <<< oss_r) + 59'sd2;
  assign h_adj    = h_n + (h_n[58] ? 59'sd3 : 59'sd0);
  assign h_qs     = g_q_r[48:2];
  assign h_x3_nxt = h_qs + 48'(btpc_pkg::B4_BIAS);

  // stage I: up - b3, ac4 product
  logic               i_v_r, i_err_r;
  logic signed [57:0] i_diff_nxt, i_diff_r;
  logic signed [64:0] i_b4p_nxt, i_b4p_r;
  logic [15:0]        i_t_r;

  assign i_diff_nxt = $signed({1'b0, h_up_r}) - h_b3_r;
  assign i_b4p_nxt  = $signed({1'b0, ac4}) * h_x3_r;

  // stage J: b7, b4
  logic               j_v_r, j_err_r;
  logic [15:0]        j_mul;
  logic signed [74:0] j_b7_nxt, j_b7_r;
  logic signed [49:0] j_b4_r;
  logic [15:0]        j_t_r;

  assign j_mul    = 16'(btpc_pkg::PRESS_SCALE >> oss_r);
  assign j_b7_nxt = i_diff_r * $signed({1'b0, j_mul});

  // pressure divider
  btpc_pkg::div_num_t  pdiv_num;
  logic                pdiv_v;
  btpc_pkg::div_res_t  pdiv_res;
  pside_t              ps_r [btpc_pkg::DIV_LAT];
  pside_t              ps_out;

  assign pdiv_num = $signed({j_b7_r, 1'b0});
  assign ps_out   = ps_r[btpc_pkg::DIV_LAT-1];

  btpc_div u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (j_v_r),
    .in_num    (pdiv_num),
    .in_den    (j_b4_r),
    .out_valid (pdiv_v),
    .out_res   (pdiv_res)
  );

  // stage K: classify quotient, correction products
  logic        k_v_r, k_err_r;
  pmode_t      k_mode_nxt, k_mode_r;
  logic [17:0] k_p_nxt, k_p_r;
  logic [19:0] k_hh_nxt, k_hh_r;
  logic [30:0] k_pm_nxt, k_pm_r;
  logic [15:0] k_t_r;

  assign k_p_nxt  = pdiv_res.mag[17:0];
  assign k_hh_nxt = k_p_nxt[17:8] * k_p_nxt[17:8];
  assign k_pm_nxt = k_p_nxt * 13'(btpc_pkg::CURVE_LIN);

  always_comb begin
    if (pdiv_res.dz) begin
      k_mode_nxt = PM_ZERO;
    end else if (pdiv_res.neg && (pdiv_res.ovf || pdiv_res.mag != '0)) begin
      k_mode_nxt = PM_ZERO;
    end else if (pdiv_res.ovf || pdiv_res.mag > btpc_pkg::div_q_t'(btpc_pkg::P_RAW_LIMIT)) begin
      k_mode_nxt = PM_MAX;
    end else begin
      k_mode_nxt = PM_CALC;
    end
  end

  // stage L: output register
  logic [31:0]        l_c1p;
  logic signed [31:0] l_npm;
  logic signed [15:0] l_c2;
  logic signed [18:0] l_sum;
  logic signed [19:0] l_pres;
  logic [16:0]        l_clip, l_pa;
  logic [15:0]        out_t_r;
  logic [16:0]        out_p_r;
  logic               out_err_r;

  assign l_c1p  = k_hh_r * 12'(btpc_pkg::CURVE_SQ);
  assign l_npm  = -$signed({1'b0, k_pm_r});
  assign l_c2   = l_npm[31:16];
  assign l_sum  = $signed({3'b000, l_c1p[31:16]}) + l_c2 + 19'(btpc_pkg::CURVE_OFS);
  assign l_pres = $signed({2'b00, k_p_r}) + $signed(l_sum[18:4]);

  always_comb begin
    if (l_pres < 20'sd0) begin
      l_clip = '0;
    end else if (l_pres > 20'(btpc_pkg::P_MAX)) begin
      l_clip = 17'(btpc_pkg::P_MAX);
    end else begin
      l_clip = l_pres[16:0];
    end
    case (k_mode_r)
      PM_CALC: l_pa = l_clip;
      PM_ZERO: l_pa = '0;
      PM_MAX:  l_pa = 17'(btpc_pkg::P_MAX);
      default: l_pa = '0;
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r        <= 1'b0;
      b_v_r        <= 1'b0;
      d_v_r        <= 1'b0;
      e_v_r        <= 1'b0;
      f_v_r        <= 1'b0;
      g_v_r        <= 1'b0;
      h_v_r        <= 1'b0;
      i_v_r        <= 1'b0;
      j_v_r        <= 1'b0;
      k_v_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      a_v_r        <= in_tvalid;
      b_v_r        <= a_v_r;
      d_v_r        <= tdiv_v;
      e_v_r        <= d_v_r;
      f_v_r        <= e_v_r;
      g_v_r        <= f_v_r;
      h_v_r        <= g_v_r;
      i_v_r        <= h_v_r;
      j_v_r        <= i_v_r;
      k_v_r        <= pdiv_v;
      out_tvalid_r <= k_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ce) begin
      a_ut_r   <= in_tdata[15:0];
      a_up_r   <= in_tdata[39:16];
      b_prod_r <= b_prod_nxt;
      b_up_r   <= a_up_r;
      ts_r[0]  <= '{x1: c_x1, up: b_up_r};
      for (int i = 1; i < btpc_pkg::DIV_LAT; i++) begin
        ts_r[i] <= ts_r[i-1];
      end
      d_b5_r   <= d_b5_nxt;
      d_err_r  <= tdiv_res.dz;
      d_up_r   <= ts_out.up;
      e_t_r    <= e_t_nxt;
      e_err_r  <= d_err_r;
      e_up_r   <= d_up_r;
      e_sqp_r  <= e_sqp_nxt;
      e_a2_r   <= e_a2_nxt;
      e_a3_r   <= e_a3_nxt;
      f_b2sq_r <= f_b2sq_nxt;
      f_b1sq_r <= f_b1sq_nxt;
      f_a2_r   <= e_a2_r;
      f_a3_r   <= e_a3_r;
      f_t_r    <= e_t_r;
      f_err_r  <= e_err_r;
      f_up_r   <= e_up_r;
      g_s_r    <= g_s_nxt;
      g_q_r    <= g_q_nxt;
      g_t_r    <= f_t_r;
      g_err_r  <= f_err_r;
      g_up_r   <= f_up_r;
      h_b3_r   <= h_adj[58:2];
      h_x3_r   <= h_x3_nxt;
      h_t_r    <= g_t_r;
      h_err_r  <= g_err_r;
      h_up_r   <= g_up_r;
      i_diff_r <= i_diff_nxt;
      i_b4p_r  <= i_b4p_nxt;
      i_t_r    <= h_t_r;
      i_err_r  <= h_err_r;
      j_b7_r   <= j_b7_nxt;
      j_b4_r   <= i_b4p_r[64:15];
      j_t_r    <= i_t_r;
      j_err_r  <= i_err_r;
      ps_r[0]  <= '{t: j_t_r, err: j_err_r};
      for (int i = 1; i < btpc_pkg::DIV_LAT; i++) begin
        ps_r[i] <= ps_r[i-1];
      end
      k_mode_r  <= k_mode_nxt;
      k_p_r     <= k_p_nxt;
      k_hh_r    <= k_hh_nxt;
      k_pm_r    <= k_pm_nxt;
      k_t_r     <= ps_out.t;
      k_err_r   <= ps_out.err | pdiv_res.dz;
      out_t_r   <= k_t_r;
      out_p_r   <= l_pa;
      out_err_r <= k_err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_err_r, out_p_r, out_t_r};

  `BTPC_ASSERT_NEXT(a_stall_holds, !ce, $stable(d_v_r) && $stable(j_v_r) && $stable(k_v_r), "stage valid moved during stall")
  `BTPC_ASSERT_IMPLY(a_out_rise, $rose(out_tvalid_r), $past(ce) && $past(k_v_r), "output valid rose without pipeline advance")

endmodule
